@@ rtl/mdm_pkg.sv @@
// Package for the mecanum drive mixer: widths, constants and payload types.
// No dependencies; every other rtl file imports it.
`timescale 1ns / 1ps
package mdm_pkg;

  localparam int WHEELS     = 4;
  localparam int AXIS_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int CTR_W      = AXIS_W + 1;
  localparam int VEC_W      = CTR_W + 1;
  localparam int MAG_W      = 9;
  localparam int DIV_STEPS  = DUTY_W;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [CTR_W-1:0] AXIS_CENTRE = 9'sd127;
  localparam logic signed [CTR_W-1:0] DEAD_LOW    = -9'sd7;
  localparam logic signed [CTR_W-1:0] DEAD_HIGH   = 9'sd8;
  localparam logic [MAG_W-1:0]        DUTY_MAX    = 9'd255;

  localparam logic [CFG_ADDR_W-3:0] REG_MASK_IDX = 1'b0;

  typedef struct packed {
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_z;
  } mdm_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] wheel0_fwd_duty;
    logic [DUTY_W-1:0] wheel0_rev_duty;
    logic [DUTY_W-1:0] wheel1_fwd_duty;
    logic [DUTY_W-1:0] wheel1_rev_duty;
    logic [DUTY_W-1:0] wheel2_fwd_duty;
    logic [DUTY_W-1:0] wheel2_rev_duty;
    logic [DUTY_W-1:0] wheel3_fwd_duty;
    logic [DUTY_W-1:0] wheel3_rev_duty;
  } mdm_out_t;

  // classified item: wheel magnitudes, positive flags and the peak magnitude
  typedef struct packed {
    logic [WHEELS-1:0][MAG_W-1:0] mag;
    logic [WHEELS-1:0]            pos;
    logic [MAG_W-1:0]             peak;
  } mdm_item_t;

  // one slot of the divider pipeline
  typedef struct packed {
    logic                          scale;
    logic [MAG_W-1:0]              peak;
    logic [WHEELS-1:0]             pos;
    logic [WHEELS-1:0][MAG_W-1:0]  rem;
    logic [WHEELS-1:0][DUTY_W-1:0] lo;
    logic [WHEELS-1:0][DUTY_W-1:0] q;
  } mdm_div_t;

endpackage

@@ rtl/mdm_front.sv @@
// Front end: takes joystick samples, centers them, applies the dead zone,
// mixes into wheel magnitudes and finds the peak. Depends on mdm_pkg.
`timescale 1ns / 1ps
module mdm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mdm_pkg::mdm_in_t    in_data,
  output logic                item_valid,
  input  logic                item_ready,
  output mdm_pkg::mdm_item_t  item_data
);
  import mdm_pkg::*;

  logic                      a_valid_r;
  logic signed [CTR_W-1:0]   cx_r, cy_r, cz_r;
  logic signed [CTR_W-1:0]   cx_nxt, cy_nxt, cz_nxt;
  logic signed [VEC_W-1:0]   x, y, z;
  logic signed [VEC_W-1:0]   vec [WHEELS];
  logic [WHEELS-1:0][MAG_W-1:0] mag;
  logic [WHEELS-1:0]         pos;
  logic [MAG_W-1:0]          m01, m23;

  function automatic logic signed [CTR_W-1:0] centre(input logic [AXIS_W-1:0] raw);
    logic signed [CTR_W-1:0] v;
    v = $signed({1'b0, raw}) - AXIS_CENTRE;
    if (v > DEAD_LOW && v < DEAD_HIGH) begin
      v = '0;
    end
    return v;
  endfunction

  assign in_ready = !a_valid_r || item_ready;

  always_comb begin
    cx_nxt = centre(in_data.axis_x);
    cy_nxt = centre(in_data.axis_y);
    cz_nxt = centre(in_data.axis_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
  end

  always_comb begin
    x = VEC_W'(cx_r);
    y = VEC_W'(cy_r);
    z = VEC_W'(cz_r);
    vec[0] = x + y + z;
    vec[1] = -x + y + z;
    vec[2] = -x + y - z;
    vec[3] = x + y - z;
    for (int w = 0; w < WHEELS; w++) begin
      mag[w] = vec[w][VEC_W-1] ? MAG_W'(-vec[w]) : MAG_W'(vec[w]);
      pos[w] = !vec[w][VEC_W-1] && (vec[w] != '0);
    end
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    m23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    item_data.mag  = mag;
    item_data.pos  = pos;
    item_data.peak = (m01 > m23) ? m01 : m23;
  end

  assign item_valid = a_valid_r;

endmodule

@@ rtl/mdm_fifo.sv @@
// Short queue of classified items between the front end and the divider.
// Depends on mdm_pkg.
`timescale 1ns / 1ps
module mdm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  mdm_pkg::mdm_item_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mdm_pkg::mdm_item_t pop_data
);
  import mdm_pkg::*;

  mdm_item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]       count_r, count_nxt;
  logic                   push, pop;

  assign push_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/mdm_back.sv @@
// Back end: per-wheel eight-stage restoring divider scales magnitudes by 255/peak
// when the peak exceeds 255; duties then map to fwd/rev outputs. Depends on mdm_pkg.
`timescale 1ns / 1ps
module mdm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  output logic                item_ready,
  input  mdm_pkg::mdm_item_t  item_data,
  input  logic [mdm_pkg::WHEELS-1:0] rev_mask,
  output logic                out_valid,
  input  logic                out_ready,
  output mdm_pkg::mdm_out_t   out_data
);
  import mdm_pkg::*;

  logic [DIV_STEPS-1:0] vld_r;
  mdm_div_t             st_r [DIV_STEPS];
  logic                 out_valid_r;
  mdm_out_t             out_data_r;
  logic                 en;

  function automatic mdm_div_t div_load(input mdm_item_t it);
    mdm_div_t                 s;
    logic [MAG_W+DUTY_W-1:0]  dvd;
    s.scale = (it.peak > DUTY_MAX);
    s.peak  = it.peak;
    s.pos   = it.pos;
    for (int w = 0; w < WHEELS; w++) begin
      dvd = {it.mag[w], {DUTY_W{1'b0}}} - (MAG_W+DUTY_W)'(it.mag[w]);
      if (s.scale) begin
        s.rem[w] = dvd[MAG_W+DUTY_W-1:DUTY_W];
        s.lo[w]  = dvd[DUTY_W-1:0];
        s.q[w]   = '0;
      end else begin
        s.rem[w] = '0;
        s.lo[w]  = '0;
        s.q[w]   = it.mag[w][DUTY_W-1:0];
      end
    end
    return s;
  endfunction

  function automatic mdm_div_t div_step(input mdm_div_t s);
    mdm_div_t         n;
    logic [MAG_W:0]   r2;
    n = s;
    for (int w = 0; w < WHEELS; w++) begin
      r2 = {s.rem[w], s.lo[w][DUTY_W-1]};
      if (s.scale) begin
        n.lo[w] = {s.lo[w][DUTY_W-2:0], 1'b0};
        if (r2 >= {1'b0, s.peak}) begin
          n.rem[w] = MAG_W'(r2 - {1'b0, s.peak});
          n.q[w]   = {s.q[w][DUTY_W-2:0], 1'b1};
        end else begin
          n.rem[w] = r2[MAG_W-1:0];
          n.q[w]   = {s.q[w][DUTY_W-2:0], 1'b0};
        end
      end
    end
    return n;
  endfunction

  function automatic mdm_out_t duty_map(input mdm_div_t s, input logic [WHEELS-1:0] m);
    mdm_out_t          o;
    logic [DUTY_W-1:0] fwd [WHEELS];
    logic [DUTY_W-1:0] rev [WHEELS];
    for (int w = 0; w < WHEELS; w++) begin
      if (s.pos[w] != m[w]) begin
        fwd[w] = s.q[w];
        rev[w] = '0;
      end else begin
        fwd[w] = '0;
        rev[w] = s.q[w];
      end
    end
    o.wheel0_fwd_duty = fwd[0];
    o.wheel0_rev_duty = rev[0];
    o.wheel1_fwd_duty = fwd[1];
    o.wheel1_rev_duty = rev[1];
    o.wheel2_fwd_duty = fwd[2];
    o.wheel2_rev_duty = rev[2];
    o.wheel3_fwd_duty = fwd[3];
    o.wheel3_rev_duty = rev[3];
    return o;
  endfunction

  assign en         = !out_valid_r || out_ready;
  assign item_ready = en;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DIV_STEPS-2:0], item_valid};
      out_valid_r <= vld_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_load(item_data);
      for (int k = 1; k < DIV_STEPS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
      out_data_r <= duty_map(div_step(st_r[DIV_STEPS-1]), rev_mask);
    end
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(vld_r))
    else $error("divider pipeline moved while output stalled");

  a_one_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.wheel0_fwd_duty == '0 || out_data_r.wheel0_rev_duty == '0)
                 && (out_data_r.wheel1_fwd_duty == '0 || out_data_r.wheel1_rev_duty == '0)
                 && (out_data_r.wheel2_fwd_duty == '0 || out_data_r.wheel2_rev_duty == '0)
                 && (out_data_r.wheel3_fwd_duty == '0 || out_data_r.wheel3_rev_duty == '0))
    else $error("both duties of a wheel driven");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DIV_STEPS-1] && st_r[DIV_STEPS-1].scale |->
      st_r[DIV_STEPS-1].rem[0] < st_r[DIV_STEPS-1].peak
      && st_r[DIV_STEPS-1].rem[1] < st_r[DIV_STEPS-1].peak
      && st_r[DIV_STEPS-1].rem[2] < st_r[DIV_STEPS-1].peak
      && st_r[DIV_STEPS-1].rem[3] < st_r[DIV_STEPS-1].peak)
    else $error("divider remainder not below peak");
`endif

endmodule

@@ rtl/mecanum_drive_mixer.sv @@
// Mecanum drive mixer: turns three joystick axes into forward/reverse PWM
// duty pairs for four wheels. One item per clock is sustained while
// out_ready stays high; a sample passes in turn through the centering
// register, the four-entry queue and the eight-step restoring divider per
// wheel that scales magnitudes by 255/peak when the peak exceeds 255.
// Depends on mdm_pkg, mdm_front, mdm_fifo and mdm_back.
`timescale 1ns / 1ps
module mecanum_drive_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mdm_pkg::mdm_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mdm_pkg::mdm_out_t                   out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mdm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mdm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mdm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import mdm_pkg::*;

  logic [WHEELS-1:0] rev_mask_r;
  logic              sel_mask;
  logic              f_valid, f_ready, b_valid, b_ready;
  mdm_item_t         f_data, b_data;

  assign pready   = 1'b1;
  assign sel_mask = (paddr[CFG_ADDR_W-1:2] == REG_MASK_IDX);
  assign prdata   = sel_mask ? CFG_DATA_W'(rev_mask_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_mask_r <= '0;
    end else if (psel && penable && pwrite && pready && sel_mask) begin
      rev_mask_r <= pwdata[WHEELS-1:0];
    end
  end

  mdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_data  (f_data)
  );

  mdm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  mdm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item_data  (b_data),
    .rev_mask   (rev_mask_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ verif/tb.sv @@
// Testbench for mecanum_drive_mixer: checks every duty pair against an in-bench wheel mixer.
// Covers directed axis corners, mask register writes and random samples under valid/ready gaps.
// Depends on rtl/mdm_pkg.sv and rtl/mecanum_drive_mixer.sv.
`timescale 1ns / 1ps
module tb;
  import mdm_pkg::*;

  localparam int CENTER_RAW   = 127;
  localparam int DEAD_HI      = 8;
  localparam int DEAD_LO      = -7;
  localparam int FULL_DUTY    = 255;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES       = 4;

  localparam logic [CFG_ADDR_W-1:0] MASK_ADDR  = {REG_MASK_IDX, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~REG_MASK_IDX, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mdm_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  mdm_out_t              out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mdm_out_t              expected_duties[$];
  logic [WHEELS-1:0]     reverse_mask_shadow;
  int                    gap_pct;
  int                    mismatches;
  int                    stall_cycles;
  mdm_out_t              want;
  logic [7:0][7:0]       got_bytes;
  logic [7:0][7:0]       want_bytes;

  mecanum_drive_mixer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int centered_axis(logic [7:0] raw);
    int v;
    v = int'(raw) - CENTER_RAW;
    if (v < DEAD_HI && v > DEAD_LO) v = 0;
    return v;
  endfunction

  function automatic mdm_out_t mix_wheel_duties(mdm_in_t s, logic [WHEELS-1:0] rmask);
    int              x, y, z, peak, duty;
    int              vec[WHEELS];
    int              mag[WHEELS];
    logic [7:0]      fwd, rev, t;
    logic [7:0][7:0] flat;
    x = centered_axis(s.axis_x);
    y = centered_axis(s.axis_y);
    z = centered_axis(s.axis_z);
    vec[0] = x + y + z;
    vec[1] = -x + y + z;
    vec[2] = -x + y - z;
    vec[3] = x + y - z;
    peak = 0;
    for (int i = 0; i < WHEELS; i++) begin
      mag[i] = (vec[i] < 0) ? -vec[i] : vec[i];
      if (mag[i] > peak) peak = mag[i];
    end
    for (int i = 0; i < WHEELS; i++) begin
      duty = mag[i];
      if (peak > FULL_DUTY) duty = (duty * FULL_DUTY) / peak;
      fwd = '0;
      rev = '0;
      if (vec[i] > 0) fwd = 8'(duty);
      else rev = 8'(duty);
      if (rmask[i]) begin
        t   = fwd;
        fwd = rev;
        rev = t;
      end
      flat[7 - 2*i] = fwd;
      flat[6 - 2*i] = rev;
    end
    return mdm_out_t'(flat);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // result side: random stalls, in-order compare
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_duties.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want       = expected_duties.pop_front();
        got_bytes  = out_data;
        want_bytes = want;
        for (int f = 0; f < 2*WHEELS; f++) begin
          if (got_bytes[7-f] !== want_bytes[7-f])
            report_mismatch($sformatf("wheel%0d %s duty: got %0d want %0d", f/2,
                                      (f % 2) ? "rev" : "fwd", got_bytes[7-f],
                                      want_bytes[7-f]));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= gap_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("mecanum_drive_mixer verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input logic [7:0] ax, input logic [7:0] ay, input logic [7:0] az);
    mdm_in_t s;
    s.axis_x = ax;
    s.axis_y = ay;
    s.axis_z = az;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_duties.push_back(mix_wheel_duties(s, reverse_mask_shadow));
  endtask

  // sender holds off until every pending result has been taken
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == MASK_ADDR) reverse_mask_shadow = data[WHEELS-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_axis();
    logic [7:0] r;
    case ($urandom_range(3))
      0: r = 8'($urandom_range(255));
      1: r = 8'($urandom_range(CENTER_RAW + DEAD_HI + 3, CENTER_RAW + DEAD_LO - 3));
      2: r = ($urandom_range(1)) ? 8'($urandom_range(255, 250)) : 8'($urandom_range(5));
      default: r = 8'($urandom_range(255));
    endcase
    return r;
  endfunction

  task automatic test_axis_corners();
    write_register(MASK_ADDR, '0);
    send_sample(8'd127, 8'd127, 8'd127);
    send_sample(8'd121, 8'd134, 8'd121);
    send_sample(8'd120, 8'd127, 8'd127);
    send_sample(8'd135, 8'd127, 8'd127);
    send_sample(8'd127, 8'd135, 8'd127);
    send_sample(8'd127, 8'd127, 8'd120);
    send_sample(8'd0,   8'd0,   8'd0);
    send_sample(8'd255, 8'd255, 8'd255);
    send_sample(8'd255, 8'd254, 8'd127);
    send_sample(8'd255, 8'd255, 8'd127);
    send_sample(8'd0,   8'd255, 8'd0);
    send_sample(8'd255, 8'd0,   8'd255);
    send_sample(8'd0,   8'd127, 8'd255);
    send_sample(8'd255, 8'd127, 8'd0);
    send_sample(8'd1,   8'd2,   8'd253);
    send_sample(8'd128, 8'd128, 8'd128);
    send_sample(8'd200, 8'd60,  8'd90);
    send_sample(8'd170, 8'd85,  8'd127);
  endtask

  task automatic test_reverse_mask();
    write_register(MASK_ADDR, 32'hF);
    send_sample(8'd0,   8'd0,   8'd0);
    send_sample(8'd255, 8'd255, 8'd255);
    send_sample(8'd255, 8'd0,   8'd127);
    send_sample(8'd127, 8'd127, 8'd127);
    // write to a spare register must leave the mask alone
    write_register(SPARE_ADDR, 32'h0);
    send_sample(8'd0,   8'd200, 8'd40);
    // only the low mask bits are kept
    write_register(MASK_ADDR, 32'hFFFF_FFF5);
    send_sample(8'd0,   8'd255, 8'd255);
    send_sample(8'd255, 8'd0,   8'd0);
    write_register(MASK_ADDR, 32'hA);
    send_sample(8'd0,   8'd255, 8'd255);
    send_sample(8'd255, 8'd0,   8'd0);
  endtask

  task automatic test_random_samples();
    int per_phase;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_register(MASK_ADDR, 32'($urandom_range(15)));
        1: write_register(MASK_ADDR, 32'hF);
        2: write_register(MASK_ADDR, {$urandom} | 32'hF0);
        default: write_register(MASK_ADDR, '0);
      endcase
      gap_pct = (p == 2) ? 0 : 15;
      for (int n = 0; n < per_phase; n++) begin
        if (n == per_phase / 2) wait_idle();
        send_sample(pick_axis(), pick_axis(), pick_axis());
      end
    end
    gap_pct = 15;
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_data             <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    reverse_mask_shadow = '0;
    gap_pct             = 15;
    mismatches          = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_axis_corners();
    test_reverse_mask();
    test_random_samples();
    wait_idle();

    if (mismatches == 0) begin
      $display("mecanum_drive_mixer verification clean");
    end else begin
      $display("mecanum_drive_mixer verification failed");
    end
    $finish;
  end

endmodule
